// File: rtl/core/dmxxf_pkg.sv
// Shared types and constants for the DMX scene crossfader.
// Holds the request/result payload structs, op codes and register indexes.
// No dependencies.
`default_nettype none

package dmxxf_pkg;

  localparam int unsigned OP_W  = 2;
  localparam int unsigned SCN_W = 4;
  localparam int unsigned CHN_W = 9;
  localparam int unsigned LVL_W = 8;
  localparam int unsigned FAD_W = 17;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;

  // Request op codes
  localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
  localparam logic [OP_W-1:0] OP_SELECT = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd2;
  localparam logic [OP_W-1:0] OP_READ   = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_STEP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_EN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCENE_COUNT = 2'd2;

  // Q16 fade position of 1.0 and register reset values
  localparam logic [FAD_W-1:0] FADE_ONE        = 17'h10000;
  localparam logic [FAD_W-1:0] FADE_STEP_RST   = 17'd655;
  localparam logic [4:0]       SCENE_COUNT_RST = 5'd0;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [SCN_W-1:0] scene;
    logic [CHN_W-1:0] channel;
    logic [LVL_W-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic [CHN_W-1:0] channel_out;
    logic [LVL_W-1:0] level;
  } out_res_t;

endpackage

`default_nettype wire

// File: rtl/core/dmxxf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the scene store copies. No dependencies.
`default_nettype none

module dmxxf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: rtl/core/dmx_scene_crossfader_unit.sv
// DMX scene crossfader top level: request decode, fade state, scene store and mixer.
// Depends on dmxxf_pkg and dmxxf_ram.
`default_nettype none

// Usage
//   Requests enter on in_req and are taken at a rising edge with start high
//   and busy low. Ops: write a scene byte, select a scene, frame tick, read a
//   channel. Only an enabled read produces a result.
//   Results appear on out_res for one cycle with out_valid high; the receiver
//   must take them then, it cannot stall the block.
//   Configuration goes through cfg_we/cfg_idx/cfg_wdata: index 0 fade step
//   (Q16), 1 output enable, 2 scene count. Write only while the block is idle.
// Timing
//   One request per cycle while busy is low. A read result passes first
//   through the registered scene memory read, then through the mix multiply
//   and output register.
//   The scene store is held twice (source and target copy), so both bytes of
//   a channel are read in the same cycle; writes go to both copies.
// Reset
//   rst_n resets the control registers and starts a clearing pass over the
//   scene store, one entry per cycle over all 2**(scene bits + channel bits)
//   entries (8192 at the default sizes). busy stays high for that pass.
module dmx_scene_crossfader_unit #(
  parameter int unsigned NUM_CHANNELS = 512,
  parameter int unsigned NUM_SCENES   = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire dmxxf_pkg::in_req_t                   in_req,
  output logic                                      out_valid,
  output dmxxf_pkg::out_res_t                       out_res,
  input  wire logic                                 cfg_we,
  input  wire logic [dmxxf_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  wire logic [dmxxf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  import dmxxf_pkg::*;

  // Only scene numbers that fit the scene field can ever be stored
  localparam int unsigned SCN_EFF = (NUM_SCENES < 16) ? NUM_SCENES : 16;
  localparam int unsigned SC_W    = (SCN_EFF > 1) ? $clog2(SCN_EFF) : 1;
  localparam int unsigned CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned ADDR_W  = SC_W + CH_W;
  localparam int unsigned DEPTH   = 2 ** ADDR_W;
  localparam logic [SCN_W:0] SCN_LIM = (SCN_W + 1)'(SCN_EFF);
  localparam logic [CHN_W:0] CHN_LIM = (CHN_W + 1)'(NUM_CHANNELS);

  // Configuration
  logic [FAD_W-1:0] fade_step_r;
  logic             out_en_r;
  logic [4:0]       scene_cnt_r;

  // Fade state
  logic [SCN_W-1:0] src_r, src_nxt;
  logic [SCN_W-1:0] tgt_r, tgt_nxt;
  logic [FAD_W-1:0] fade_r, fade_nxt;

  // Clearing pass
  logic              clr_busy_r;
  logic [ADDR_W-1:0] clr_addr_r;

  // Read pipeline
  logic             s1_valid_r;
  logic             s1_zero_r;
  logic [CHN_W-1:0] s1_ch_r;
  logic [FAD_W-1:0] s1_f_r;
  logic             out_valid_r;
  out_res_t         out_res_r;

  logic              accept;
  logic              wr_ok, sel_ok, ch_ok;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [LVL_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0] src_raddr, tgt_raddr;
  logic [LVL_W-1:0]  src_byte, tgt_byte;
  logic [FAD_W:0]    fade_sum;

  logic signed [LVL_W:0]         mix_diff;
  logic signed [FAD_W:0]         mix_f;
  logic signed [LVL_W+FAD_W+1:0] mix_prod;
  logic [LVL_W+2:0]              mix_sum;

  assign busy   = clr_busy_r;
  assign accept = start && !clr_busy_r;

  assign wr_ok  = ({1'b0, in_req.scene} < SCN_LIM) && ({1'b0, in_req.channel} < CHN_LIM);
  assign sel_ok = ({1'b0, in_req.scene} < scene_cnt_r) && ({1'b0, in_req.scene} < SCN_LIM);
  assign ch_ok  = {1'b0, in_req.channel} < CHN_LIM;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_step_r <= FADE_STEP_RST;
      out_en_r    <= 1'b1;
      scene_cnt_r <= SCENE_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_FADE_STEP:   fade_step_r <= cfg_wdata[FAD_W-1:0];
        CFG_OUTPUT_EN:   out_en_r    <= cfg_wdata[0];
        CFG_SCENE_COUNT: scene_cnt_r <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // Select and tick update the fade state
  assign fade_sum = {1'b0, fade_r} + {1'b0, fade_step_r};

  always_comb begin
    src_nxt  = src_r;
    tgt_nxt  = tgt_r;
    fade_nxt = fade_r;
    if (accept) begin
      case (in_req.op)
        OP_SELECT: begin
          if (sel_ok) begin
            src_nxt  = tgt_r;
            tgt_nxt  = in_req.scene;
            fade_nxt = '0;
          end
        end
        OP_TICK: begin
          if (out_en_r && (scene_cnt_r != 5'd0)) begin
            // saturate at 1.0
            fade_nxt = (fade_sum > {1'b0, FADE_ONE}) ? FADE_ONE : fade_sum[FAD_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r  <= '0;
      tgt_r  <= '0;
      fade_r <= FADE_ONE;
    end else begin
      src_r  <= src_nxt;
      tgt_r  <= tgt_nxt;
      fade_r <= fade_nxt;
    end
  end

  // Clear the scene store after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // Memory access: writes and reads happen at the edge the request is taken,
  // so a read always sees every earlier write.
  assign ram_we    = clr_busy_r || (accept && (in_req.op == OP_WRITE) && wr_ok);
  assign ram_waddr = clr_busy_r ? clr_addr_r
                                : {in_req.scene[SC_W-1:0], in_req.channel[CH_W-1:0]};
  assign ram_wdata = clr_busy_r ? '0 : in_req.value;
  assign src_raddr = {src_r[SC_W-1:0], in_req.channel[CH_W-1:0]};
  assign tgt_raddr = {tgt_r[SC_W-1:0], in_req.channel[CH_W-1:0]};

  dmxxf_ram #(
    .WIDTH (LVL_W),
    .DEPTH (DEPTH)
  ) u_src_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (src_raddr),
    .rdata (src_byte)
  );

  dmxxf_ram #(
    .WIDTH (LVL_W),
    .DEPTH (DEPTH)
  ) u_tgt_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (tgt_raddr),
    .rdata (tgt_byte)
  );

  // Stage 1: hold read context while the memories respond
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept && (in_req.op == OP_READ) && out_en_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_zero_r <= (scene_cnt_r == 5'd0) || !ch_ok;
    s1_ch_r   <= in_req.channel;
    s1_f_r    <= fade_r;
  end

  // Stage 2: level = src + floor((dst - src) * f / 2^16)
  assign mix_diff = $signed({1'b0, tgt_byte}) - $signed({1'b0, src_byte});
  assign mix_f    = $signed({1'b0, s1_f_r});
  assign mix_prod = (LVL_W + FAD_W + 2)'(mix_diff * mix_f);
  assign mix_sum  = {3'b000, src_byte} + mix_prod[LVL_W+FAD_W+1:FAD_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r.channel_out <= s1_ch_r;
    out_res_r.level       <= s1_zero_r ? '0 : mix_sum[LVL_W-1:0];
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

`ifndef SYNTH
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !s1_valid_r)
    else $error("read in flight during scene store clear");

  a_result_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(s1_valid_r))
    else $error("result without a read in stage 1");

  a_fade_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fade_r <= FADE_ONE)
    else $error("fade position above 1.0");

  a_select_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_req.op == OP_SELECT) && sel_ok) |=> (fade_r == '0) && (src_r == $past(tgt_r)))
    else $error("select did not restart the fade");
`endif

endmodule

`default_nettype wire
